// ===== src/lcd4_pkg.sv =====
package lcd4_pkg;

    // Register file and counter widths
    localparam int CFG_W = 16;
    localparam int CNT_W = 16;
    localparam int IDX_W = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ENABLE_HIGH = 3'd0;
    localparam logic [IDX_W-1:0] REG_NIBBLE_GAP  = 3'd1;
    localparam logic [IDX_W-1:0] REG_BYTE_SETTLE = 3'd2;
    localparam logic [IDX_W-1:0] REG_POWER_ON    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CLEAR_EXTRA = 3'd4;

    // Reset values of the timing registers
    localparam logic [CFG_W-1:0] RST_ENABLE_HIGH = 16'd1;
    localparam logic [CFG_W-1:0] RST_NIBBLE_GAP  = 16'd200;
    localparam logic [CFG_W-1:0] RST_BYTE_SETTLE = 16'd2000;
    localparam logic [CFG_W-1:0] RST_POWER_ON    = 16'd20000;
    localparam logic [CFG_W-1:0] RST_CLEAR_EXTRA = 16'd2000;

    // Fixed LCD command bytes
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_HOME_ROW0 = 8'h80;

    typedef enum logic [2:0] {
        ACT_TICK  = 3'd0,
        ACT_CMD   = 3'd1,
        ACT_CHAR  = 3'd2,
        ACT_MOVE  = 3'd3,
        ACT_INIT  = 3'd4,
        ACT_CLEAR = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_NONE     = 2'd0,
        ST_ACCEPTED = 2'd1,
        ST_BUSY     = 2'd2,
        ST_BAD_COL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_POWER  = 3'd1,
        PH_UP_EN  = 3'd2,
        PH_GAP    = 3'd3,
        PH_LO_EN  = 3'd4,
        PH_SETTLE = 3'd5,
        PH_EXTRA  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        MK_NONE  = 2'd0,
        MK_INIT  = 2'd1,
        MK_CLEAR = 2'd2
    } macro_t;

    typedef struct packed {
        logic [CFG_W-1:0] enable_high_ticks;
        logic [CFG_W-1:0] nibble_gap_ticks;
        logic [CFG_W-1:0] byte_settle_ticks;
        logic [CFG_W-1:0] power_on_ticks;
        logic [CFG_W-1:0] clear_extra_ticks;
    } lcd4_cfg_t;

    typedef struct packed {
        status_t    status;
        logic       busy_res;
        logic       enable;
        logic       reg_select;
        logic [3:0] data_nibble;
    } lcd4_res_t;

    // Power-up command list, one byte per macro step
    function automatic logic [7:0] init_byte(input logic [2:0] idx);
        logic [7:0] b;
        begin
            unique case (idx)
                3'd0:    b = 8'h02;
                3'd1:    b = 8'h28;
                3'd2:    b = 8'h0C;
                3'd3:    b = 8'h06;
                default: b = 8'h01;
            endcase
            return b;
        end
    endfunction

    // Zero duration counts as one tick
    function automatic logic [CNT_W-1:0] clamp_dur(input logic [CFG_W-1:0] v);
        begin
            return (v == '0) ? CNT_W'(1) : CNT_W'(v);
        end
    endfunction

endpackage

// ===== src/lcd_four_bit_write_sequencer.sv =====
// Channel  | Dir | Fields (lowest bit up)                                    | Accept
// ---------+-----+-----------------------------------------------------------+-------------------
// s_axis   | in  | tuser: action[2:0]                                        | tvalid & tready
//          |     | tdata: byte_value[7:0] row[8] column[13:9], zero [15:14]  |
// m_axis   | out | tdata: data_nibble[3:0] reg_select[4] enable[5]           | tvalid & tready
//          |     |        busy_res[6] status[8:7], zero [15:9]               |
// cfg      | in  | cfg_index selects the timing register, cfg_data its value | cfg_we
//
// One tick request enters per clock while m_axis is not stalled; each result passes
// the input register, then the result register, after its request is taken.
// The sequencer update in lcd4_seq finishes one tick per cycle when the result register has room.
// Reset (rst_n low) clears the phase to idle and loads the default timing values.
// A stalled m_axis holds the result register; the input register still takes a request
// whenever the result register is free or drains in the same cycle.
module lcd_four_bit_write_sequencer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [15:0]               s_axis_tdata,  // byte_value, row, column
    input  logic [2:0]                s_axis_tuser,  // action
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [15:0]               m_axis_tdata,  // data_nibble, reg_select, enable,
                                                     // busy_res, status
    input  logic                      cfg_we,
    input  logic [lcd4_pkg::IDX_W-1:0] cfg_index,
    input  logic [lcd4_pkg::CFG_W-1:0] cfg_data
);
    import lcd4_pkg::*;

    lcd4_cfg_t  cfg;
    lcd4_res_t  res;

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic [2:0] action_reg;
    logic [7:0] byte_reg;
    logic       row_reg;
    logic [4:0] column_reg;

    // Result register
    logic       out_valid_reg, out_valid_next;
    lcd4_res_t  res_reg;

    logic       s_fire;
    logic       proc;

    // Process the held request when the result register has room
    assign proc          = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = s_fire || (in_valid_reg && !proc);
    assign out_valid_next = proc || (out_valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture request payload
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            action_reg <= s_axis_tuser;
            byte_reg   <= s_axis_tdata[7:0];
            row_reg    <= s_axis_tdata[8];
            column_reg <= s_axis_tdata[13:9];
        end
    end

    // Capture result payload
    always_ff @(posedge clk)
    begin
        if (proc)
            res_reg <= res;
    end

    lcd4_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcd4_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .step       (proc),
        .action     (action_reg),
        .byte_value (byte_reg),
        .row        (row_reg),
        .column     (column_reg),
        .res        (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, res_reg.status, res_reg.busy_res, res_reg.enable,
                            res_reg.reg_select, res_reg.data_nibble};

endmodule

// ===== src/lcd4_cfg.sv =====
module lcd4_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lcd4_pkg::IDX_W-1:0] cfg_index,
    input  logic [lcd4_pkg::CFG_W-1:0] cfg_data,
    output lcd4_pkg::lcd4_cfg_t       cfg
);
    import lcd4_pkg::*;

    lcd4_cfg_t cfg_reg;
    lcd4_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENABLE_HIGH: cfg_next.enable_high_ticks = cfg_data;
                REG_NIBBLE_GAP:  cfg_next.nibble_gap_ticks  = cfg_data;
                REG_BYTE_SETTLE: cfg_next.byte_settle_ticks = cfg_data;
                REG_POWER_ON:    cfg_next.power_on_ticks    = cfg_data;
                REG_CLEAR_EXTRA: cfg_next.clear_extra_ticks = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_high_ticks <= RST_ENABLE_HIGH;
            cfg_reg.nibble_gap_ticks  <= RST_NIBBLE_GAP;
            cfg_reg.byte_settle_ticks <= RST_BYTE_SETTLE;
            cfg_reg.power_on_ticks    <= RST_POWER_ON;
            cfg_reg.clear_extra_ticks <= RST_CLEAR_EXTRA;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lcd4_seq.sv =====
module lcd4_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcd4_pkg::lcd4_cfg_t  cfg,
    input  logic                 step,
    input  logic [2:0]           action,
    input  logic [7:0]           byte_value,
    input  logic                 row,
    input  logic [4:0]           column,
    output lcd4_pkg::lcd4_res_t  res
);
    import lcd4_pkg::*;

    phase_t           phase_reg,  phase_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic [7:0]       byte_reg,   byte_next;
    logic             sel_reg,    sel_next;
    macro_t           kind_reg,   kind_next;
    logic [2:0]       mstep_reg,  mstep_next;
    logic [3:0]       nib_reg,    nib_next;
    logic             en_reg,     en_next;

    always_comb
    begin
        phase_t           ph;
        logic [CNT_W-1:0] cnt;
        logic [7:0]       byt;
        logic             sel;
        macro_t           kind;
        logic [2:0]       stp;
        logic [3:0]       nib;
        logic             en;
        logic             nxt;
        status_t          st;

        ph   = phase_reg;
        cnt  = cnt_reg;
        byt  = byte_reg;
        sel  = sel_reg;
        kind = kind_reg;
        stp  = mstep_reg;
        nib  = nib_reg;
        en   = en_reg;
        nxt  = 1'b0;
        st   = ST_NONE;

        // Request decode: busy check first, then column check
        if (action >= ACT_CMD && action <= ACT_CLEAR)
        begin
            if (phase_reg != PH_IDLE)
            begin
                st = ST_BUSY;
            end
            else if (action == ACT_MOVE && column[4])
            begin
                st = ST_BAD_COL;
            end
            else
            begin
                st   = ST_ACCEPTED;
                stp  = '0;
                kind = MK_NONE;
                sel  = (action == ACT_CHAR);
                unique case (action)
                    ACT_CMD, ACT_CHAR: byt = byte_value;
                    ACT_MOVE:          byt = {1'b1, row, 2'b00, column[3:0]};
                    default:           byt = CMD_CLEAR;
                endcase
                if (action == ACT_INIT)
                begin
                    kind = MK_INIT;
                    byt  = byte_reg;
                    sel  = sel_reg;
                    ph   = PH_POWER;
                    cnt  = clamp_dur(cfg.power_on_ticks);
                    en   = 1'b0;
                end
                else
                begin
                    if (action == ACT_CLEAR)
                        kind = MK_CLEAR;
                    ph  = PH_UP_EN;
                    cnt = clamp_dur(cfg.enable_high_ticks);
                    nib = byt[7:4];
                    en  = 1'b1;
                end
            end
        end

        // Lines as seen this tick
        res.data_nibble = nib;
        res.reg_select  = sel;
        res.enable      = (ph != PH_IDLE) & en;

        // Count down the current phase and advance when it runs out
        if (ph != PH_IDLE)
        begin
            if (cnt != '0)
                cnt = cnt - CNT_W'(1);
            if (cnt == '0)
            begin
                unique case (ph)
                    PH_POWER:
                    begin
                        stp = '0;
                        byt = init_byte(3'd0);
                        sel = 1'b0;
                        ph  = PH_UP_EN;
                        cnt = clamp_dur(cfg.enable_high_ticks);
                        nib = byt[7:4];
                        en  = 1'b1;
                    end
                    PH_UP_EN:
                    begin
                        ph  = PH_GAP;
                        cnt = clamp_dur(cfg.nibble_gap_ticks);
                        en  = 1'b0;
                    end
                    PH_GAP:
                    begin
                        ph  = PH_LO_EN;
                        cnt = clamp_dur(cfg.enable_high_ticks);
                        nib = byt[3:0];
                        en  = 1'b1;
                    end
                    PH_LO_EN:
                    begin
                        ph  = PH_SETTLE;
                        cnt = clamp_dur(cfg.byte_settle_ticks);
                        en  = 1'b0;
                    end
                    PH_SETTLE:
                    begin
                        // The clear command gets an extra wait when configured
                        if (((kind == MK_INIT && stp == 3'd4) ||
                             (kind == MK_CLEAR && stp == 3'd0)) &&
                            cfg.clear_extra_ticks != '0)
                        begin
                            ph  = PH_EXTRA;
                            cnt = clamp_dur(cfg.clear_extra_ticks);
                            en  = 1'b0;
                        end
                        else
                        begin
                            nxt = 1'b1;
                        end
                    end
                    default: nxt = 1'b1;
                endcase

                if (nxt)
                begin
                    if ((kind == MK_INIT && stp < 3'd4) ||
                        (kind == MK_CLEAR && stp < 3'd1))
                    begin
                        stp = stp + 3'd1;
                        byt = (kind == MK_INIT) ? init_byte(stp) : CMD_HOME_ROW0;
                        sel = 1'b0;
                        ph  = PH_UP_EN;
                        cnt = clamp_dur(cfg.enable_high_ticks);
                        nib = byt[7:4];
                        en  = 1'b1;
                    end
                    else
                    begin
                        ph   = PH_IDLE;
                        cnt  = '0;
                        en   = 1'b0;
                        kind = MK_NONE;
                        stp  = '0;
                    end
                end
            end
        end

        res.busy_res = (ph != PH_IDLE);
        res.status   = st;

        phase_next = ph;
        cnt_next   = cnt;
        byte_next  = byt;
        sel_next   = sel;
        kind_next  = kind;
        mstep_next = stp;
        nib_next   = nib;
        en_next    = en;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            byte_reg  <= '0;
            sel_reg   <= 1'b0;
            kind_reg  <= MK_NONE;
            mstep_reg <= '0;
            nib_reg   <= '0;
            en_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            byte_reg  <= byte_next;
            sel_reg   <= sel_next;
            kind_reg  <= kind_next;
            mstep_reg <= mstep_next;
            nib_reg   <= nib_next;
            en_reg    <= en_next;
        end
    end

endmodule

// ===== src/lcd4_checker.sv =====
module lcd4_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_axis_tvalid,
    input logic                      s_axis_tready,
    input logic [15:0]               s_axis_tdata,
    input logic [2:0]                s_axis_tuser,
    input logic                      m_axis_tvalid,
    input logic                      m_axis_tready,
    input logic [15:0]               m_axis_tdata,
    input logic                      cfg_we,
    input logic [lcd4_pkg::IDX_W-1:0] cfg_index,
    input logic [lcd4_pkg::CFG_W-1:0] cfg_data
);
    import lcd4_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // Enable strobe only inside a running sequence
    a_en_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[6])
        else $error("enable high while not busy");

    // An accepted request always leaves a sequence running
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:7] == ST_ACCEPTED |-> m_axis_tdata[6])
        else $error("accepted request left block idle");

    // Refused column comes only from an idle block, nothing driven
    a_bad_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8:7] == ST_BAD_COL |->
            !m_axis_tdata[6] && !m_axis_tdata[5])
        else $error("bad column while busy or strobing");

endmodule

bind lcd_four_bit_write_sequencer lcd4_checker u_lcd4_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

// ===== test/lcd_seq_checker.sv =====
`timescale 1ns / 1ps

// Watches the request and result channels and the register port, keeps its own
// model of the LCD sequencer and compares every result with the oldest prediction.
module lcd_seq_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [15:0]                s_tdata,   // byte_value[7:0] row[8] column[13:9]
    input  logic [2:0]                 s_tuser,   // action[2:0]
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [15:0]                m_tdata,   // data_nibble[3:0] reg_select[4] enable[5]
                                                  // busy_res[6] status[8:7]
    input  logic                       cfg_we,
    input  logic [lcd4_pkg::IDX_W-1:0] cfg_index,
    input  logic [lcd4_pkg::CFG_W-1:0] cfg_data,
    output int                         fail_count,
    output int                         pending
);
    import lcd4_pkg::*;

    lcd4_cfg_t        timing;
    phase_t           seq_phase;
    logic [CNT_W-1:0] hold_cnt;
    logic [7:0]       cur_byte;
    logic             cur_sel;
    macro_t           seq_macro;
    logic [2:0]       macro_step;
    logic [3:0]       pins_nib;
    logic             pins_en;

    lcd4_res_t        expected_pins_q[$];
    int               fails = 0;
    int               pending_n = 0;

    assign fail_count = fails;
    assign pending    = pending_n;

    // Power-up command list
    function automatic logic [7:0] power_up_cmd(input logic [2:0] step);
        logic [7:0] b;
        case (step)
            3'd0:    b = 8'h02;
            3'd1:    b = 8'h28;
            3'd2:    b = 8'h0C;
            3'd3:    b = 8'h06;
            default: b = 8'h01;
        endcase
        return b;
    endfunction

    function automatic logic [CNT_W-1:0] ticks_of(input logic [CFG_W-1:0] v);
        logic [CNT_W-1:0] d;
        d = v;
        if (d == '0)
            d = CNT_W'(1);
        return d;
    endfunction

    function void enter_phase(input phase_t p, input logic [CFG_W-1:0] dur);
        seq_phase = p;
        hold_cnt  = ticks_of(dur);
        case (p)
            PH_UP_EN:
            begin
                pins_nib = cur_byte[7:4];
                pins_en  = 1'b1;
            end
            PH_LO_EN:
            begin
                pins_nib = cur_byte[3:0];
                pins_en  = 1'b1;
            end
            default: pins_en = 1'b0;
        endcase
    endfunction

    function void load_byte(input logic [7:0] b, input logic sel);
        cur_byte = b;
        cur_sel  = sel;
        enter_phase(PH_UP_EN, timing.enable_high_ticks);
    endfunction

    function void next_step();
        if (seq_macro == MK_INIT && macro_step < 3'd4)
        begin
            macro_step = macro_step + 3'd1;
            load_byte(power_up_cmd(macro_step), 1'b0);
        end
        else if (seq_macro == MK_CLEAR && macro_step < 3'd1)
        begin
            macro_step = macro_step + 3'd1;
            load_byte(CMD_HOME_ROW0, 1'b0);
        end
        else
        begin
            seq_phase  = PH_IDLE;
            hold_cnt   = '0;
            pins_en    = 1'b0;
            seq_macro  = MK_NONE;
            macro_step = 3'd0;
        end
    endfunction

    function void phase_done();
        case (seq_phase)
            PH_POWER:
            begin
                macro_step = 3'd0;
                load_byte(power_up_cmd(3'd0), 1'b0);
            end
            PH_UP_EN: enter_phase(PH_GAP, timing.nibble_gap_ticks);
            PH_GAP:   enter_phase(PH_LO_EN, timing.enable_high_ticks);
            PH_LO_EN: enter_phase(PH_SETTLE, timing.byte_settle_ticks);
            PH_SETTLE:
            begin
                // The clear command of either macro gets the extra wait
                if (((seq_macro == MK_INIT && macro_step == 3'd4) ||
                     (seq_macro == MK_CLEAR && macro_step == 3'd0)) &&
                    timing.clear_extra_ticks != '0)
                    enter_phase(PH_EXTRA, timing.clear_extra_ticks);
                else
                    next_step();
            end
            default: next_step();
        endcase
    endfunction

    // One tick of the sequencer: returns the pin levels and status it produces
    function lcd4_res_t lcd_tick(input logic [2:0] act, input logic [15:0] dat);
        lcd4_res_t  r;
        status_t    st;
        logic [7:0] bval;
        logic       row;
        logic [4:0] col;
        bval = dat[7:0];
        row  = dat[8];
        col  = dat[13:9];
        st   = ST_NONE;
        if (act >= ACT_CMD && act <= ACT_CLEAR)
        begin
            if (seq_phase != PH_IDLE)
                st = ST_BUSY;
            else if (act == ACT_MOVE && col >= 5'd16)
                st = ST_BAD_COL;
            else
            begin
                st         = ST_ACCEPTED;
                macro_step = 3'd0;
                seq_macro  = MK_NONE;
                case (act)
                    ACT_CMD:  load_byte(bval, 1'b0);
                    ACT_CHAR: load_byte(bval, 1'b1);
                    ACT_MOVE: load_byte({(row ? 4'hC : 4'h8), col[3:0]}, 1'b0);
                    ACT_INIT:
                    begin
                        seq_macro = MK_INIT;
                        enter_phase(PH_POWER, timing.power_on_ticks);
                    end
                    default:
                    begin
                        seq_macro = MK_CLEAR;
                        load_byte(CMD_CLEAR, 1'b0);
                    end
                endcase
            end
        end
        r.data_nibble = pins_nib;
        r.reg_select  = cur_sel;
        r.enable      = (seq_phase != PH_IDLE) ? pins_en : 1'b0;
        if (seq_phase != PH_IDLE)
        begin
            if (hold_cnt != '0)
                hold_cnt = hold_cnt - 1'b1;
            if (hold_cnt == '0)
                phase_done();
        end
        r.busy_res = (seq_phase != PH_IDLE);
        r.status   = st;
        return r;
    endfunction

    function void reset_model();
        timing.enable_high_ticks = RST_ENABLE_HIGH;
        timing.nibble_gap_ticks  = RST_NIBBLE_GAP;
        timing.byte_settle_ticks = RST_BYTE_SETTLE;
        timing.power_on_ticks    = RST_POWER_ON;
        timing.clear_extra_ticks = RST_CLEAR_EXTRA;
        seq_phase  = PH_IDLE;
        hold_cnt   = '0;
        cur_byte   = 8'h00;
        cur_sel    = 1'b0;
        seq_macro  = MK_NONE;
        macro_step = 3'd0;
        pins_nib   = 4'h0;
        pins_en    = 1'b0;
        expected_pins_q.delete();
    endfunction

    task automatic report_mismatch(input string what);
        fails++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        lcd4_res_t want;
        lcd4_res_t got;
        if (!rst_n)
        begin
            reset_model();
            pending_n = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ENABLE_HIGH: timing.enable_high_ticks = cfg_data;
                    REG_NIBBLE_GAP:  timing.nibble_gap_ticks  = cfg_data;
                    REG_BYTE_SETTLE: timing.byte_settle_ticks = cfg_data;
                    REG_POWER_ON:    timing.power_on_ticks    = cfg_data;
                    REG_CLEAR_EXTRA: timing.clear_extra_ticks = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_pins_q.push_back(lcd_tick(s_tuser, s_tdata));
            if (m_tvalid && m_tready)
            begin
                if (expected_pins_q.size() == 0)
                    report_mismatch($sformatf("result %h with nothing expected", m_tdata));
                else
                begin
                    want = expected_pins_q.pop_front();
                    got  = lcd4_res_t'(m_tdata[8:0]);
                    if (^m_tdata === 1'bx)
                        report_mismatch($sformatf("result %h has unknown bits", m_tdata));
                    else
                    begin
                        if (got.data_nibble != want.data_nibble)
                            report_mismatch($sformatf("data_nibble %h, want %h",
                                                      got.data_nibble, want.data_nibble));
                        if (got.reg_select != want.reg_select)
                            report_mismatch($sformatf("reg_select %b, want %b",
                                                      got.reg_select, want.reg_select));
                        if (got.enable != want.enable)
                            report_mismatch($sformatf("enable %b, want %b",
                                                      got.enable, want.enable));
                        if (got.busy_res != want.busy_res)
                            report_mismatch($sformatf("busy_res %b, want %b",
                                                      got.busy_res, want.busy_res));
                        if (got.status != want.status)
                            report_mismatch($sformatf("status %0d, want %0d",
                                                      got.status, want.status));
                        if (m_tdata[15:9] != 7'd0)
                            report_mismatch($sformatf("pad bits %h not zero", m_tdata[15:9]));
                    end
                end
            end
            pending_n = expected_pins_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the LCD four-bit write sequencer. Every input item is one
// tick; the checker beside the block predicts the pin levels of each tick.
module tb_top;
    import lcd4_pkg::*;

    // Actions 6 and 7 are spare codes the block treats as plain ticks
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             s_tvalid;
    logic             s_tready;
    logic [15:0]      s_tdata;   // byte_value[7:0] row[8] column[13:9], zero above
    logic [2:0]       s_tuser;   // action[2:0]
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [15:0]      m_tdata;   // data_nibble[3:0] reg_select[4] enable[5]
                                 // busy_res[6] status[8:7]
    logic             cfg_we;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;

    int   fail_count;
    int   pending;
    int   sent_n     = 0;
    int   recv_n     = 0;
    int   accepted_n = 0;
    int   refused_n  = 0;
    int   settings_n = 0;
    int   rx_hold    = 0;
    logic last_busy  = 1'b0;
    bit   tx_calm    = 1'b0;
    bit   rx_calm    = 1'b0;

    lcd_four_bit_write_sequencer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    lcd_seq_checker u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #4 clk = ~clk;

    // Idle length: mostly short, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pack_item(input logic [7:0] b, input logic row,
                                              input logic [4:0] col);
        return {2'b00, col, row, b};
    endfunction

    function automatic logic [15:0] rand_fields();
        return pack_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         5'($urandom_range(0, 31)));
    endfunction

    // Timing value for random phases: mostly tiny, zero included, a few longer
    function automatic logic [15:0] rand_dur();
        if ($urandom_range(0, 99) < 80)
            return 16'($urandom_range(0, 6));
        return 16'($urandom_range(7, 40));
    endfunction

    // Result side: count each result, keep its busy bit, and stall at random
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            recv_n++;
            last_busy = m_tdata[6];
            if (m_tdata[8:7] == ST_ACCEPTED)
                accepted_n++;
            else if (m_tdata[8:7] == ST_BUSY || m_tdata[8:7] == ST_BAD_COL)
                refused_n++;
        end
        if (rx_calm)
            m_tready <= 1'b1;
        else if (rx_hold > 0)
        begin
            rx_hold--;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 99) < 15)
        begin
            rx_hold = gap_len() - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Offer one tick request, after an optional gap; leave valid high on return
    task automatic send_item(input logic [2:0] act, input logic [15:0] dat);
        int n;
        n = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= dat;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_n++;
    endtask

    function automatic logic [2:0] rand_tick_action();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return ACT_SPARE_LO;
        else if (r == 1)
            return ACT_SPARE_HI;
        return ACT_TICK;
    endfunction

    // Mixed random tick, mostly requests that land while the block may be busy
    task automatic send_random();
        int         r;
        logic [2:0] act;
        r = $urandom_range(0, 99);
        if (r < 40)
            act = ACT_TICK;
        else if (r < 55)
            act = ACT_CMD;
        else if (r < 72)
            act = ACT_CHAR;
        else if (r < 84)
            act = ACT_MOVE;
        else if (r < 88)
            act = ACT_INIT;
        else if (r < 96)
            act = ACT_CLEAR;
        else
            act = ($urandom_range(0, 1) == 0) ? ACT_SPARE_LO : ACT_SPARE_HI;
        send_item(act, rand_fields());
    endtask

    // Drop valid and collect every result still in the pipeline
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (recv_n != sent_n)
            @(posedge clk);
    endtask

    // Drain, then keep ticking until a result shows the sequence has finished,
    // and let the pipeline empty
    task automatic wait_idle();
        drain();
        while (last_busy)
            send_item(rand_tick_action(), rand_fields());
        s_tvalid <= 1'b0;
        while (recv_n != sent_n)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_put(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    // Write all five timing registers back to back; only called with the pipeline empty
    task automatic set_timing(input logic [15:0] eh, input logic [15:0] gap,
                              input logic [15:0] settle, input logic [15:0] pwr,
                              input logic [15:0] extra);
        cfg_put(REG_ENABLE_HIGH, eh);
        cfg_put(REG_NIBBLE_GAP, gap);
        cfg_put(REG_BYTE_SETTLE, settle);
        cfg_put(REG_POWER_ON, pwr);
        cfg_put(REG_CLEAR_EXTRA, extra);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_n++;
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 16'h0000;
        s_tuser   <= ACT_TICK;
        cfg_we    <= 1'b0;
        cfg_index <= REG_ENABLE_HIGH;
        cfg_data  <= 16'h0000;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset timing: one command, then requests while it runs; the move with a
        // bad column must come back busy, since busy is checked first. Once those
        // results are back, shorten the timing so the running command ends soon
        settings_n = 1;
        send_item(ACT_TICK, pack_item(8'h00, 1'b0, 5'd0));
        send_item(ACT_CMD, pack_item(8'hFF, 1'b1, 5'd31));
        send_item(ACT_MOVE, pack_item(8'h00, 1'b0, 5'd20));
        send_item(ACT_CHAR, pack_item(8'h41, 1'b0, 5'd0));
        drain();
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        wait_idle();

        // Shortest timing, no extra wait after clear
        set_timing(16'd1, 16'd1, 16'd1, 16'd1, 16'd0);
        send_item(ACT_CMD, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_CHAR, pack_item(8'hFF, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_MOVE, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_MOVE, pack_item(8'hFF, 1'b1, 5'd15));
        wait_idle();
        send_item(ACT_MOVE, pack_item(8'h00, 1'b0, 5'd16));
        send_item(ACT_MOVE, pack_item(8'hFF, 1'b1, 5'd31));
        send_item(ACT_SPARE_LO, pack_item(8'h00, 1'b0, 5'd0));
        send_item(ACT_SPARE_HI, pack_item(8'hFF, 1'b1, 5'd31));
        send_item(ACT_INIT, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_CLEAR, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();

        // Zero durations count as one tick
        set_timing(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_item(ACT_CLEAR, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_INIT, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();

        // Short timing with an extra wait after each clear command
        set_timing(16'd1, 16'd2, 16'd3, 16'd2, 16'd3);
        send_item(ACT_CLEAR, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();
        send_item(ACT_INIT, pack_item(8'h00, 1'b0, 5'd0));
        wait_idle();

        // Random phases, each under fresh small timing; some without idling
        for (int k = 0; k < 6; k++)
        begin
            set_timing(rand_dur(), rand_dur(), rand_dur(), rand_dur(), rand_dur());
            tx_calm = (k == 2);
            rx_calm = (k == 2 || k == 4);
            repeat (60) send_random();
            wait_idle();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;

        // Drain and let the last results settle before the verdict
        wait_idle();
        repeat (10) @(posedge clk);
        $display("Ran %0d ticks under %0d timing settings: %0d requests accepted, %0d refused.",
                 sent_n, settings_n, accepted_n, refused_n);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
        begin
            $display("%0d mismatches, %0d expected results never arrived", fail_count, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hold a hard stop far beyond the slowest correct run
    initial
    begin
        #20ms;
        $display("Timed out after %0d ticks sent, %0d results seen", sent_n, recv_n);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
